/* rtl/assert_macros.svh */
// Assertion macros for the checker file mase_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge of aclk, ignored while in reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Check on every rising edge of aclk, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

/* rtl/mase_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mase_pkg;

    localparam int MAX_DIM = 8;
    localparam int DIM_W   = 3;
    localparam int CNT_W   = 4;
    localparam int VAL_W   = 16;
    localparam int RES_W   = 36;
    localparam int PROD_W  = 2 * VAL_W;

    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_SUB  = 2'd1,
        OP_MUL  = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_OP    = 2'd0,
        CFG_ROWS  = 2'd1,
        CFG_INNER = 2'd2,
        CFG_COLS  = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic                    valid;
        logic signed [VAL_W-1:0] a;
        logic [DIM_W-1:0]        t;
        logic [DIM_W-1:0]        j;
        logic                    first;
        logic                    lastt;
    } tok_t;

    function automatic logic [DIM_W-1:0] clamp_m1(input logic [CNT_W-1:0] n);
        logic [DIM_W-1:0] r;
        if (n == '0) begin
            r = '0;
        end else if (n > CNT_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM - 1);
        end else begin
            r = DIM_W'(n - CNT_W'(1));
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/mase_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module mase_cell import mase_pkg::*; (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire op_t                     mode,
    input  wire logic [DIM_W-1:0]        col_id,
    input  wire logic                    wr_en,
    input  wire logic [DIM_W-1:0]        wr_addr,
    input  wire logic signed [VAL_W-1:0] wr_data,
    input  wire tok_t                    tok_in,
    output tok_t                         tok_out,
    output logic signed [RES_W-1:0]      acc,
    output logic                         done
);

    logic signed [VAL_W-1:0] bmem [MAX_DIM];
    logic signed [VAL_W-1:0] b_rd_reg;
    tok_t                    tok_reg;
    logic                    v2_reg, first2_reg, last2_reg, done_reg, hit2_reg;
    logic signed [RES_W-1:0] term_reg, term_next;
    logic signed [RES_W-1:0] acc_reg, acc_next;
    logic signed [PROD_W-1:0] prod;
    logic signed [VAL_W:0]    sum;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            bmem[wr_addr] <= wr_data;
        end
        b_rd_reg <= bmem[(mode == OP_MUL) ? tok_in.t : tok_in.j];
    end

    always_comb begin
        prod = tok_reg.a * b_rd_reg;
        if (mode == OP_SUB) begin
            sum = (VAL_W+1)'(tok_reg.a) - (VAL_W+1)'(b_rd_reg);
        end else begin
            sum = (VAL_W+1)'(tok_reg.a) + (VAL_W+1)'(b_rd_reg);
        end
        if (mode == OP_MUL) begin
            term_next = RES_W'(prod);
        end else begin
            term_next = RES_W'(sum) <<< 8;
        end
        acc_next = ((first2_reg || mode != OP_MUL) ? RES_W'(0) : acc_reg) + term_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg  <= '0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            tok_reg  <= tok_in;
            v2_reg   <= tok_reg.valid;
            done_reg <= v2_reg && last2_reg;
        end
        term_reg   <= term_next;
        first2_reg <= tok_reg.first;
        last2_reg  <= tok_reg.lastt;
        hit2_reg   <= (tok_reg.t == col_id);
        if (v2_reg && (mode == OP_MUL || hit2_reg)) begin
            acc_reg <= acc_next;
        end
    end

    assign tok_out = tok_reg;
    assign acc     = acc_reg;
    assign done    = done_reg;

endmodule

`default_nettype wire

/* rtl/matrix_add_sub_mul_engine_core.sv */
// Channel   | Direction | Handshake          | Payload
// s_        | in        | s_valid / s_ready  | s_func s_row s_col s_value s_last
// m_        | out       | m_valid / m_ready  | m_out_row m_out_col m_result m_final_res
// cfg_      | in        | cfg_wr_en          | cfg_addr cfg_wdata
//
// One request is loaded per cycle while s_ready is high. A request with s_last starts
// the run unless the op is OP_NONE; s_ready stays low until the last result is in the
// output register. Each result row is fed for inner steps (cols for add/sub), drains
// until its last token crossed the used cells, then emits column by column, waiting
// on m_ready. Reset is synchronous on aresetn; the element stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module matrix_add_sub_mul_engine_core import mase_pkg::*; (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_wr_en,
    input  wire logic [1:0]              cfg_addr,
    input  wire logic [CNT_W-1:0]        cfg_wdata,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic                    s_func,
    input  wire logic [DIM_W-1:0]        s_row,
    input  wire logic [DIM_W-1:0]        s_col,
    input  wire logic signed [VAL_W-1:0] s_value,
    input  wire logic                    s_last,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic [DIM_W-1:0]             m_out_row,
    output logic [DIM_W-1:0]             m_out_col,
    output logic signed [RES_W-1:0]      m_result,
    output logic                         m_final_res
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FEED,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    op_t    op_reg;
    logic [CNT_W-1:0] rows_reg, inner_reg, cols_reg;
    logic [DIM_W-1:0] j_reg, j_next, t_reg, t_next, c_reg, c_next;
    logic             feed_v_reg, feed_v_next;
    logic [DIM_W-1:0] feed_t_reg, feed_j_reg;
    logic             feed_first_reg, feed_lastt_reg;
    logic signed [VAL_W-1:0] amem [MAX_DIM*MAX_DIM];
    logic signed [VAL_W-1:0] a_rd_reg;
    logic             m_valid_reg, m_valid_next, m_final_reg;
    logic [DIM_W-1:0] m_row_reg, m_col_reg;
    logic signed [RES_W-1:0] m_result_reg;
    logic [DIM_W-1:0] rows_m1, cols_m1, inner_m1;
    logic             s_acc, emit;

    tok_t                    tok [MAX_DIM+1];
    logic signed [RES_W-1:0] cell_acc [MAX_DIM];
    logic [MAX_DIM-1:0]      cell_done;

    assign rows_m1  = clamp_m1(rows_reg);
    assign cols_m1  = clamp_m1(cols_reg);
    assign inner_m1 = (op_reg == OP_MUL) ? clamp_m1(inner_reg) : cols_m1;
    assign s_ready  = (state_reg == ST_IDLE);
    assign s_acc    = s_valid && s_ready;
    assign emit     = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg    <= OP_MUL;
            rows_reg  <= CNT_W'(MAX_DIM);
            inner_reg <= CNT_W'(MAX_DIM);
            cols_reg  <= CNT_W'(MAX_DIM);
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_OP:    op_reg    <= op_t'(cfg_wdata[1:0]);
                CFG_ROWS:  rows_reg  <= cfg_wdata;
                CFG_INNER: inner_reg <= cfg_wdata;
                CFG_COLS:  cols_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc && !s_func) begin
            amem[{s_row, s_col}] <= s_value;
        end
        a_rd_reg <= amem[{j_reg, t_reg}];
    end

    always_comb begin
        state_next   = state_reg;
        j_next       = j_reg;
        t_next       = t_reg;
        c_next       = c_reg;
        feed_v_next  = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc && s_last && op_reg != OP_NONE) begin
                    state_next = ST_FEED;
                    j_next     = '0;
                    t_next     = '0;
                end
            end
            ST_FEED: begin
                feed_v_next = 1'b1;
                t_next      = t_reg + DIM_W'(1);
                if (t_reg == inner_m1) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (cell_done[cols_m1]) begin
                    state_next = ST_EMIT;
                    c_next     = '0;
                end
            end
            ST_EMIT: begin
                if (emit) begin
                    m_valid_next = 1'b1;
                    c_next       = c_reg + DIM_W'(1);
                    if (c_reg == cols_m1) begin
                        t_next = '0;
                        j_next = j_reg + DIM_W'(1);
                        state_next = (j_reg == rows_m1) ? ST_IDLE : ST_FEED;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            feed_v_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            j_reg       <= '0;
            t_reg       <= '0;
            c_reg       <= '0;
        end else begin
            state_reg   <= state_next;
            feed_v_reg  <= feed_v_next;
            m_valid_reg <= m_valid_next;
            j_reg       <= j_next;
            t_reg       <= t_next;
            c_reg       <= c_next;
        end
        feed_t_reg     <= t_reg;
        feed_j_reg     <= j_reg;
        feed_first_reg <= (t_reg == '0);
        feed_lastt_reg <= (t_reg == inner_m1);
        if (emit) begin
            m_row_reg    <= j_reg;
            m_col_reg    <= c_reg;
            m_result_reg <= cell_acc[c_reg];
            m_final_reg  <= (j_reg == rows_m1) && (c_reg == cols_m1);
        end
    end

    always_comb begin
        tok[0].valid = feed_v_reg;
        tok[0].a     = a_rd_reg;
        tok[0].t     = feed_t_reg;
        tok[0].j     = feed_j_reg;
        tok[0].first = feed_first_reg;
        tok[0].lastt = feed_lastt_reg;
    end

    for (genvar c = 0; c < MAX_DIM; c++) begin : g_cell
        mase_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .mode    (op_reg),
            .col_id  (DIM_W'(c)),
            .wr_en   (s_acc && s_func && (s_col == DIM_W'(c))),
            .wr_addr (s_row),
            .wr_data (s_value),
            .tok_in  (tok[c]),
            .tok_out (tok[c+1]),
            .acc     (cell_acc[c]),
            .done    (cell_done[c])
        );
    end

    assign m_valid     = m_valid_reg;
    assign m_out_row   = m_row_reg;
    assign m_out_col   = m_col_reg;
    assign m_result    = m_result_reg;
    assign m_final_res = m_final_reg;

endmodule

`default_nettype wire

/* rtl/mase_chk.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mase_chk import mase_pkg::*; (
    input wire logic                    aclk,
    input wire logic                    aresetn,
    input wire logic                    s_valid,
    input wire logic                    s_ready,
    input wire logic                    s_last,
    input wire logic                    m_valid,
    input wire logic                    m_ready,
    input wire logic signed [RES_W-1:0] m_result
);

    `ASSERT_CLK(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_result), "stalled result changed")
    `ASSERT_ALWAYS(a_rst_idle, !aresetn |=> !m_valid && s_ready, "not idle after reset")
    `ASSERT_CLK(a_plain_load, s_valid && s_ready && !s_last |=> s_ready, "load without last blocked input")
    `ASSERT_CLK(a_busy_start, $fell(s_ready) |-> $past(s_valid && s_last), "input blocked without a last request")

endmodule

bind matrix_add_sub_mul_engine_core mase_chk u_mase_chk (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_last      (s_last),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_result    (m_result)
);

`default_nettype wire
